>>> hw/rtl/dfsh_pkg.sv
`default_nettype none

package dfsh_pkg;

    localparam int KEY_W    = 63;
    localparam int HASH_W   = 30;
    localparam int SIZE_W   = 4;
    localparam int CNT_W    = 4;
    localparam int DIGIT_W  = 4;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 32;
    localparam int CFG_W    = 32;
    localparam int ADDR_W   = 3;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = 4'd1;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 4'd9;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd2;

    typedef enum logic [0:0] {
        REG_ADDRESS_SIZE = 1'b0,
        REG_HASH_MODE    = 1'b1
    } reg_index_t;

    // settings broadcast to every fold cell
    typedef struct packed {
        logic [SIZE_W-1:0] addr_size;   // already clamped to 1..9
        logic [HASH_W-1:0] modulus;     // 10^addr_size
        logic              rotate;
    } cfg_t;

    // running fold state handed from cell to cell
    typedef struct packed {
        logic              started;     // first significant digit seen
        logic [CNT_W-1:0]  cnt;         // digits in the open group
        logic [HASH_W-1:0] acc;         // value of the open group
        logic [HASH_W-1:0] sum;         // closed groups, mod 10^addr_size
    } fold_t;

    function automatic logic [HASH_W-1:0] pow10(input logic [SIZE_W-1:0] n);
        logic [HASH_W-1:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

    // both operands below m, so one conditional subtract reduces the sum
    function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b,
                                                  input logic [HASH_W-1:0] m);
        logic [HASH_W:0] s;
        logic [HASH_W:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = s - {1'b0, m};
        return (s >= {1'b0, m}) ? t[HASH_W-1:0] : s[HASH_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dfsh_dabble_cell.sv
`default_nettype none

// Shift-and-add-3 binary to BCD, STEP_BITS key bits per cell.
// Carries out of the top digit are dropped, which leaves key mod 10^digits.
module dfsh_dabble_cell
    import dfsh_pkg::*;
#(
    parameter int BCD_W     = 76,
    parameter int STEP_BITS = 3
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [KEY_W-1:0] in_key,
    input  wire logic [BCD_W-1:0] in_bcd,
    output logic                  out_valid,
    output logic      [KEY_W-1:0] out_key,
    output logic      [BCD_W-1:0] out_bcd
);

    localparam int NDIG = BCD_W / DIGIT_W;

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;

    always_comb
    begin : dabble
        logic [KEY_W-1:0] k;
        logic [BCD_W-1:0] b;
        k = in_key;
        b = in_bcd;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (b[d*DIGIT_W +: DIGIT_W] >= 4'd5)
                begin
                    b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], k[KEY_W-1]};
            k = {k[KEY_W-2:0], 1'b0};
        end
        key_next = k;
        bcd_next = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            key_reg <= key_next;
            bcd_reg <= bcd_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_key   = key_reg;
    assign out_bcd   = bcd_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dfsh_fold_cell.sv
`default_nettype none

// One decimal digit position of the fold, most significant cell first.
module dfsh_fold_cell
    import dfsh_pkg::*;
#(
    parameter int BCD_W = 76,
    parameter int POS   = 0
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire cfg_t             cfg,
    input  wire logic             in_valid,
    input  wire logic [BCD_W-1:0] in_bcd,
    input  wire fold_t            in_fold,
    output logic                  out_valid,
    output logic      [BCD_W-1:0] out_bcd,
    output fold_t                 out_fold
);

    localparam bit LAST = (POS == 0);

    logic               valid_reg;
    logic [BCD_W-1:0]   bcd_reg;
    fold_t              fold_reg;
    fold_t              fold_next;
    logic [DIGIT_W-1:0] digit;
    logic               take;
    logic [HASH_W-1:0]  acc_mul;
    logic [CNT_W-1:0]   cnt_inc;

    assign digit = in_bcd[POS*DIGIT_W +: DIGIT_W];

    always_comb
    begin
        // in rotate mode the units digit was folded in up front
        take    = !(LAST && cfg.rotate) && (in_fold.started || digit != '0 || LAST);
        acc_mul = {in_fold.acc[HASH_W-4:0], 3'b000} + {in_fold.acc[HASH_W-2:0], 1'b0}
                  + HASH_W'(digit);
        cnt_inc = in_fold.cnt + CNT_W'(1);
        fold_next = in_fold;
        if (take)
        begin
            fold_next.started = 1'b1;
            if (cnt_inc == cfg.addr_size)
            begin
                fold_next.sum = mod_add(in_fold.sum, acc_mul, cfg.modulus);
                fold_next.acc = '0;
                fold_next.cnt = '0;
            end
            else
            begin
                fold_next.acc = acc_mul;
                fold_next.cnt = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bcd_reg  <= in_bcd;
            fold_reg <= fold_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bcd   = bcd_reg;
    assign out_fold  = fold_reg;

endmodule

`default_nettype wire

>>> hw/rtl/decimal_fold_shift_hash.sv
// Channel   Dir  Payload                                   Handshake
// s_*       in   tdata[62:0] key                           tvalid/tready
// m_*       out  tdata[29:0] hash_value                    tvalid/tready
// APB       in   0x0 address_size[3:0], 0x4 hash_mode[0]   psel/penable, pready=1
//
// One key per cycle sustained while the skid register is empty. Pipeline stages:
// 21 binary-to-BCD cells at 3 key bits each, one fold cell per digit, one output register.
// The whole cell chain moves together; it stops only when the skid register holds an item.
// An output register plus one skid register let input flow while a result waits.
// Reset (rst_n, async, low) clears all valid bits; address_size 2, hash_mode 0.
`default_nettype none

module decimal_fold_shift_hash
    import dfsh_pkg::*;
#(
    parameter int KEY_DIGITS = 19
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [62:0] key
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,   // [29:0] hash_value
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [CFG_W-1:0]    pwdata,
    output logic      [CFG_W-1:0]    prdata,
    output logic                     pready
);

    localparam int BCD_W     = DIGIT_W * KEY_DIGITS;
    localparam int STEP_BITS = 3;
    localparam int DAB_CELLS = KEY_W / STEP_BITS;

    // ---------------- configuration ----------------
    logic [SIZE_W-1:0] size_reg;
    logic              rotate_reg;
    logic              cfg_wr;
    reg_index_t        cfg_idx;
    cfg_t              cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= SIZE_RESET;
            rotate_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ADDRESS_SIZE: size_reg   <= pwdata[SIZE_W-1:0];
                REG_HASH_MODE:    rotate_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ADDRESS_SIZE: prdata = CFG_W'(size_reg);
            REG_HASH_MODE:    prdata = CFG_W'(rotate_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        if (size_reg < SIZE_MIN)
        begin
            cfg.addr_size = SIZE_MIN;
        end
        else if (size_reg > SIZE_MAX)
        begin
            cfg.addr_size = SIZE_MAX;
        end
        else
        begin
            cfg.addr_size = size_reg;
        end
        cfg.modulus = pow10(cfg.addr_size);
        cfg.rotate  = rotate_reg;
    end

    // ---------------- cell chain ----------------
    logic advance;

    logic             dab_valid [0:DAB_CELLS];
    logic [KEY_W-1:0] dab_key   [0:DAB_CELLS];
    logic [BCD_W-1:0] dab_bcd   [0:DAB_CELLS];

    logic             fold_valid [0:KEY_DIGITS];
    logic [BCD_W-1:0] fold_bcd   [0:KEY_DIGITS];
    fold_t            fold_st    [0:KEY_DIGITS];
    fold_t            fold_head;

    assign dab_valid[0] = s_tvalid;
    assign dab_key[0]   = s_tdata[KEY_W-1:0];
    assign dab_bcd[0]   = '0;

    for (genvar i = 0; i < DAB_CELLS; i++)
    begin : g_dab
        dfsh_dabble_cell #(
            .BCD_W     (BCD_W),
            .STEP_BITS (STEP_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (dab_valid[i]),
            .in_key    (dab_key[i]),
            .in_bcd    (dab_bcd[i]),
            .out_valid (dab_valid[i+1]),
            .out_key   (dab_key[i+1]),
            .out_bcd   (dab_bcd[i+1])
        );
    end

    // rotate mode: units digit opens the string
    always_comb
    begin
        fold_head = '0;
        if (cfg.rotate)
        begin
            if (cfg.addr_size == SIZE_MIN)
            begin
                fold_head.sum = HASH_W'(dab_bcd[DAB_CELLS][DIGIT_W-1:0]);
            end
            else
            begin
                fold_head.acc = HASH_W'(dab_bcd[DAB_CELLS][DIGIT_W-1:0]);
                fold_head.cnt = CNT_W'(1);
            end
        end
    end

    assign fold_st[0]    = fold_head;
    assign fold_valid[0] = dab_valid[DAB_CELLS];
    assign fold_bcd[0]   = dab_bcd[DAB_CELLS];

    for (genvar i = 0; i < KEY_DIGITS; i++)
    begin : g_fold
        dfsh_fold_cell #(
            .BCD_W (BCD_W),
            .POS   (KEY_DIGITS - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .cfg       (cfg),
            .in_valid  (fold_valid[i]),
            .in_bcd    (fold_bcd[i]),
            .in_fold   (fold_st[i]),
            .out_valid (fold_valid[i+1]),
            .out_bcd   (fold_bcd[i+1]),
            .out_fold  (fold_st[i+1])
        );
    end

    // ---------------- output register with skid ----------------
    logic              out_valid_reg;
    logic [HASH_W-1:0] out_data_reg;
    logic              skid_valid_reg;
    logic [HASH_W-1:0] skid_data_reg;
    logic [HASH_W-1:0] hash_next;
    logic              done_item;
    logic              out_free;

    assign advance   = !skid_valid_reg;
    assign s_tready  = advance;
    assign done_item = fold_valid[KEY_DIGITS] && advance;
    assign out_free  = !out_valid_reg || m_tready;
    // close the last open group
    assign hash_next = mod_add(fold_st[KEY_DIGITS].sum, fold_st[KEY_DIGITS].acc, cfg.modulus);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || done_item;
            skid_valid_reg <= 1'b0;
        end
        else if (done_item)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : hash_next;
        end
        else if (done_item)
        begin
            skid_data_reg <= hash_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_data_reg);

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output register is empty");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    a_hash_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_data_reg < cfg.modulus))
        else $error("hash not reduced below 10^address_size");

    a_size_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.addr_size >= SIZE_MIN) && (cfg.addr_size <= SIZE_MAX))
        else $error("group size outside 1..9");
`endif

endmodule

`default_nettype wire
